[hdl/irctok_pkg.sv]
package irctok_pkg;

    // Parameter slots tracked per line; the index saturates one below this.
    localparam int MAX_PARAMS = 16;
    // Completed-parameter counter must reach MAX_PARAMS itself.
    localparam int COUNT_W    = $clog2(MAX_PARAMS + 1);
    localparam int IDX_W      = 4;

    localparam logic [7:0] COLON = 8'h3A;

    typedef enum logic [2:0] {
        PH_LINE   = 3'd0,
        PH_PREWS  = 3'd1,
        PH_PREFIX = 3'd2,
        PH_CMDWS  = 3'd3,
        PH_CMD    = 3'd4,
        PH_PSTART = 3'd5,
        PH_MIDDLE = 3'd6,
        PH_TRAIL  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_PREFIX = 3'd1,
        KIND_CMD    = 3'd2,
        KIND_MIDDLE = 3'd3,
        KIND_TRAIL  = 3'd4
    } kind_t;

    typedef struct packed {
        phase_t               phase;
        logic [COUNT_W-1:0]   count;
        logic                 ovf;
    } tok_state_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             byte_valid;
        kind_t            field_kind;
        logic [IDX_W-1:0] param_index;
        logic             field_end;
        logic             line_end;
        logic             param_overflow;
    } tok_result_t;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

[hdl/irctok_in_if.sv]
interface irctok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[hdl/irctok_out_if.sv]
interface irctok_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] field_kind;
    logic [3:0] param_index;
    logic       field_end;
    logic       line_end;
    logic       param_overflow;

    modport source (
        output valid, output out_byte, output byte_valid, output field_kind,
        output param_index, output field_end, output line_end,
        output param_overflow, input ready
    );
    modport sink (
        input valid, input out_byte, input byte_valid, input field_kind,
        input param_index, input field_end, input line_end,
        input param_overflow, output ready
    );
endinterface

[hdl/irctok_classify.sv]
module irctok_classify (
    input  irctok_pkg::tok_state_t  cur,
    input  logic [7:0]              data_byte,
    input  logic                    last_byte,
    output irctok_pkg::tok_state_t  nxt,
    output irctok_pkg::tok_result_t res
);

    logic                                ws;
    logic                                valid;
    logic                                fend;
    irctok_pkg::kind_t                   kind;
    irctok_pkg::phase_t                  next_phase;
    logic                                ovf_next;
    logic [irctok_pkg::COUNT_W-1:0]      sat_idx;
    logic [irctok_pkg::COUNT_W-1:0]      count_next;
    logic                                is_param;

    assign ws = irctok_pkg::is_space(data_byte);

    // Phase decode: classify the byte and pick the next phase.
    always_comb
    begin
        valid      = 1'b0;
        fend       = 1'b0;
        kind       = irctok_pkg::KIND_NONE;
        next_phase = cur.phase;
        ovf_next   = cur.ovf;

        if ((cur.phase == irctok_pkg::PH_LINE) && (data_byte == irctok_pkg::COLON))
        begin
            kind       = irctok_pkg::KIND_PREFIX;
            next_phase = irctok_pkg::PH_PREWS;
        end
        else
        begin
            unique case (cur.phase) inside
                irctok_pkg::PH_PREWS:
                begin
                    if (!ws)
                    begin
                        valid      = 1'b1;
                        kind       = irctok_pkg::KIND_PREFIX;
                        fend       = last_byte;
                        next_phase = irctok_pkg::PH_PREFIX;
                    end
                end
                irctok_pkg::PH_PREFIX:
                begin
                    kind = irctok_pkg::KIND_PREFIX;
                    if (ws)
                    begin
                        fend       = 1'b1;
                        next_phase = irctok_pkg::PH_CMDWS;
                    end
                    else
                    begin
                        valid = 1'b1;
                        fend  = last_byte;
                    end
                end
                irctok_pkg::PH_LINE, irctok_pkg::PH_CMDWS:
                begin
                    next_phase = irctok_pkg::PH_CMDWS;
                    if (!ws)
                    begin
                        valid      = 1'b1;
                        kind       = irctok_pkg::KIND_CMD;
                        fend       = last_byte;
                        next_phase = irctok_pkg::PH_CMD;
                    end
                end
                irctok_pkg::PH_CMD:
                begin
                    kind = irctok_pkg::KIND_CMD;
                    if (ws)
                    begin
                        fend       = 1'b1;
                        next_phase = irctok_pkg::PH_PSTART;
                    end
                    else
                    begin
                        valid = 1'b1;
                        fend  = last_byte;
                    end
                end
                irctok_pkg::PH_PSTART:
                begin
                    // A parameter opens beyond the limit: flag it for the rest of the line.
                    if (cur.count >= irctok_pkg::COUNT_W'(irctok_pkg::MAX_PARAMS))
                        ovf_next = 1'b1;
                    if (data_byte == irctok_pkg::COLON)
                    begin
                        kind       = irctok_pkg::KIND_TRAIL;
                        fend       = last_byte;
                        next_phase = irctok_pkg::PH_TRAIL;
                    end
                    else if (ws)
                    begin
                        kind = irctok_pkg::KIND_MIDDLE;
                        fend = 1'b1;
                    end
                    else
                    begin
                        kind       = irctok_pkg::KIND_MIDDLE;
                        valid      = 1'b1;
                        fend       = last_byte;
                        next_phase = irctok_pkg::PH_MIDDLE;
                    end
                end
                irctok_pkg::PH_MIDDLE:
                begin
                    kind = irctok_pkg::KIND_MIDDLE;
                    if (ws)
                    begin
                        fend       = 1'b1;
                        next_phase = irctok_pkg::PH_PSTART;
                    end
                    else
                    begin
                        valid = 1'b1;
                        fend  = last_byte;
                    end
                end
                irctok_pkg::PH_TRAIL:
                begin
                    kind  = irctok_pkg::KIND_TRAIL;
                    valid = 1'b1;
                    fend  = last_byte;
                end
                default:
                begin
                    next_phase = irctok_pkg::PH_LINE;
                end
            endcase
        end
    end

    assign is_param = (kind == irctok_pkg::KIND_MIDDLE) || (kind == irctok_pkg::KIND_TRAIL);

    // Saturate the reported index one below the limit.
    assign sat_idx = (cur.count > irctok_pkg::COUNT_W'(irctok_pkg::MAX_PARAMS - 1))
                   ? irctok_pkg::COUNT_W'(irctok_pkg::MAX_PARAMS - 1)
                   : cur.count;

    always_comb
    begin
        count_next = cur.count;
        if (is_param && fend && (cur.count < irctok_pkg::COUNT_W'(irctok_pkg::MAX_PARAMS)))
            count_next = cur.count + irctok_pkg::COUNT_W'(1);
    end

    // Return to line start after the final byte.
    always_comb
    begin
        if (last_byte)
        begin
            nxt.phase = irctok_pkg::PH_LINE;
            nxt.count = '0;
            nxt.ovf   = 1'b0;
        end
        else
        begin
            nxt.phase = next_phase;
            nxt.count = count_next;
            nxt.ovf   = ovf_next;
        end
    end

    always_comb
    begin
        res.out_byte       = valid ? data_byte : 8'h00;
        res.byte_valid     = valid;
        res.field_kind     = kind;
        res.param_index    = is_param ? irctok_pkg::IDX_W'(sat_idx) : '0;
        res.field_end      = fend;
        res.line_end       = last_byte;
        res.param_overflow = ovf_next;
    end

endmodule

[hdl/irc_line_tokenizer.sv]
// Path: a byte transferred in waits in the input stage; its tag is then loaded into the
//   result register and transfers out from there.
// Throughput: one byte per cycle if the sink is ready, set by the single phase register.
// Reset (rst_n low, asynchronous): both stages empty, parser back at line start with
//   parameter count and overflow flag cleared.
module irc_line_tokenizer (
    input  logic          clk,
    input  logic          rst_n,
    irctok_in_if.sink     line_in,
    irctok_out_if.source  token_out
);

    // Input stage: holds one received byte until the classifier can advance it.
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [7:0]               s1_byte_reg;
    logic                     s1_last_reg;

    // Parser state, advanced once per classified byte.
    irctok_pkg::tok_state_t   state_reg;
    irctok_pkg::tok_state_t   state_next;

    // Result register facing the sink.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    irctok_pkg::tok_result_t  out_res_reg;
    irctok_pkg::tok_result_t  res_comb;

    logic                     in_xfer;
    logic                     advance;
    logic                     s1_adv;

    // The result register frees up when it is empty or its transfer completes.
    assign advance = !out_valid_reg || token_out.ready;
    assign s1_adv  = s1_valid_reg && advance;
    // Take a new byte whenever the input stage is empty or moving on this cycle.
    assign line_in.ready = !s1_valid_reg || advance;
    assign in_xfer       = line_in.valid && line_in.ready;

    irctok_classify u_classify (
        .cur       (state_reg),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .nxt       (state_next),
        .res       (res_comb)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = s1_valid_reg;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg.phase <= irctok_pkg::PH_LINE;
            state_reg.count <= '0;
            state_reg.ovf   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
                state_reg <= state_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_byte_reg <= line_in.data_byte;
            s1_last_reg <= line_in.last_byte;
        end
        if (s1_adv)
            out_res_reg <= res_comb;
    end

    assign token_out.valid          = out_valid_reg;
    assign token_out.out_byte       = out_res_reg.out_byte;
    assign token_out.byte_valid     = out_res_reg.byte_valid;
    assign token_out.field_kind     = out_res_reg.field_kind;
    assign token_out.param_index    = out_res_reg.param_index;
    assign token_out.field_end      = out_res_reg.field_end;
    assign token_out.line_end       = out_res_reg.line_end;
    assign token_out.param_overflow = out_res_reg.param_overflow;

`ifndef ASSERT_OFF
    // After the last byte of a line is classified, the parser is back at line start.
    a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_last_reg) |=>
            (state_reg.phase == irctok_pkg::PH_LINE && state_reg.count == '0 && !state_reg.ovf))
        else $error("parser state not cleared after line end");

    // The completed-parameter count never runs past its saturation point.
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.count <= irctok_pkg::COUNT_W'(irctok_pkg::MAX_PARAMS))
        else $error("parameter count beyond limit");

    // Field content always carries a field kind; a parameter index only on parameters.
    a_tag_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            !(out_res_reg.byte_valid && out_res_reg.field_kind == irctok_pkg::KIND_NONE) &&
            ((out_res_reg.param_index == '0) ||
             (out_res_reg.field_kind == irctok_pkg::KIND_MIDDLE) ||
             (out_res_reg.field_kind == irctok_pkg::KIND_TRAIL)))
        else $error("inconsistent field tag");

    // A byte held in the input stage moves on as soon as the result register frees up.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("input stage failed to advance");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    // Directed rows, then random lines in six traffic phases of about
    // PHASE_ITEMS transfers each.
    localparam int DIR_ROWS    = 25;
    localparam int PHASE_ITEMS = 321;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 5000;

    typedef enum int {
        MODE_FREE,
        MODE_SRC_IDLE,
        MODE_SINK_STALL,
        MODE_BOTH,
        MODE_PRESSURE
    } traffic_mode_t;

    // One directed row: the byte, its last flag and, where the tag is obvious,
    // the tag typed in by hand. Other rows are checked against the predictor.
    typedef struct {
        logic                    data;
        logic                    last;
        logic                    typed_in;
        irctok_pkg::tok_result_t tag;
    } stim_row_dummy_t;

    typedef struct {
        logic [7:0]              data;
        logic                    last;
        logic                    typed_in;
        irctok_pkg::tok_result_t tag;
    } stim_row_t;

    logic clk;
    logic rst_n;

    irctok_in_if  line_in ();
    irctok_out_if token_out ();

    irc_line_tokenizer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_in   (line_in),
        .token_out (token_out)
    );

    // Tags predicted for accepted bytes, oldest first.
    irctok_pkg::tok_result_t pending_tags[$];

    int error_count    = 0;
    int transfers_in   = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // Bumped by the stimulus to request one long receiver hold-off.
    int hold_gen       = 0;

    // Predictor state: parse phase, completed parameters of the line and
    // the sticky overflow flag.
    irctok_pkg::phase_t tag_phase   = irctok_pkg::PH_LINE;
    int unsigned        params_done = 0;
    logic               ovf_flag    = 1'b0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on either handshake.
    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic logic blank_char(input logic [7:0] b);
        return b inside {8'h20, [8'h09:8'h0D]};
    endfunction

    // Tag one byte and advance the predictor. A colon only opens a prefix as
    // the first byte of a line; anything else there starts the command hunt.
    function automatic irctok_pkg::tok_result_t classify_byte(input logic [7:0] b,
                                                              input logic last);
        irctok_pkg::phase_t      p;
        irctok_pkg::phase_t      nxt;
        logic                    ws;
        irctok_pkg::tok_result_t r;
        p  = tag_phase;
        ws = blank_char(b);
        r  = '0;
        r.field_kind = irctok_pkg::KIND_NONE;
        r.line_end   = last;
        if (p == irctok_pkg::PH_LINE && b != irctok_pkg::COLON)
            p = irctok_pkg::PH_CMDWS;
        nxt = p;
        case (p)
            irctok_pkg::PH_LINE:
            begin
                r.field_kind = irctok_pkg::KIND_PREFIX;
                nxt = irctok_pkg::PH_PREWS;
            end
            irctok_pkg::PH_PREWS:
            begin
                if (!ws)
                begin
                    r.byte_valid = 1'b1;
                    r.field_kind = irctok_pkg::KIND_PREFIX;
                    r.field_end  = last;
                    nxt = irctok_pkg::PH_PREFIX;
                end
            end
            irctok_pkg::PH_PREFIX:
            begin
                r.field_kind = irctok_pkg::KIND_PREFIX;
                if (ws)
                begin
                    r.field_end = 1'b1;
                    nxt = irctok_pkg::PH_CMDWS;
                end
                else
                begin
                    r.byte_valid = 1'b1;
                    r.field_end  = last;
                end
            end
            irctok_pkg::PH_CMDWS:
            begin
                if (!ws)
                begin
                    r.byte_valid = 1'b1;
                    r.field_kind = irctok_pkg::KIND_CMD;
                    r.field_end  = last;
                    nxt = irctok_pkg::PH_CMD;
                end
            end
            irctok_pkg::PH_CMD:
            begin
                r.field_kind = irctok_pkg::KIND_CMD;
                if (ws)
                begin
                    r.field_end = 1'b1;
                    nxt = irctok_pkg::PH_PSTART;
                end
                else
                begin
                    r.byte_valid = 1'b1;
                    r.field_end  = last;
                end
            end
            irctok_pkg::PH_PSTART:
            begin
                // A parameter opening past the limit raises overflow for the line.
                if (params_done >= irctok_pkg::MAX_PARAMS)
                    ovf_flag = 1'b1;
                if (b == irctok_pkg::COLON)
                begin
                    r.field_kind = irctok_pkg::KIND_TRAIL;
                    r.field_end  = last;
                    nxt = irctok_pkg::PH_TRAIL;
                end
                else if (ws)
                begin
                    r.field_kind = irctok_pkg::KIND_MIDDLE;
                    r.field_end  = 1'b1;
                end
                else
                begin
                    r.field_kind = irctok_pkg::KIND_MIDDLE;
                    r.byte_valid = 1'b1;
                    r.field_end  = last;
                    nxt = irctok_pkg::PH_MIDDLE;
                end
            end
            irctok_pkg::PH_MIDDLE:
            begin
                r.field_kind = irctok_pkg::KIND_MIDDLE;
                if (ws)
                begin
                    r.field_end = 1'b1;
                    nxt = irctok_pkg::PH_PSTART;
                end
                else
                begin
                    r.byte_valid = 1'b1;
                    r.field_end  = last;
                end
            end
            default:
            begin
                r.field_kind = irctok_pkg::KIND_TRAIL;
                r.byte_valid = 1'b1;
                r.field_end  = last;
            end
        endcase
        if (r.field_kind == irctok_pkg::KIND_MIDDLE || r.field_kind == irctok_pkg::KIND_TRAIL)
        begin
            r.param_index = irctok_pkg::IDX_W'(
                (params_done > irctok_pkg::MAX_PARAMS - 1) ? irctok_pkg::MAX_PARAMS - 1
                                                           : params_done);
            if (r.field_end && params_done < irctok_pkg::MAX_PARAMS)
                params_done++;
        end
        r.out_byte       = r.byte_valid ? b : 8'h00;
        r.param_overflow = ovf_flag;
        // Every line starts from a clean parser.
        if (last)
        begin
            tag_phase   = irctok_pkg::PH_LINE;
            params_done = 0;
            ovf_flag    = 1'b0;
        end
        else
            tag_phase = nxt;
        return r;
    endfunction

    function automatic irctok_pkg::tok_result_t tag(input logic [7:0] ob, input logic bv,
                                                    input irctok_pkg::kind_t kd,
                                                    input logic [3:0] ix, input logic fe,
                                                    input logic le, input logic ov);
        irctok_pkg::tok_result_t t;
        t.out_byte       = ob;
        t.byte_valid     = bv;
        t.field_kind     = kd;
        t.param_index    = ix;
        t.field_end      = fe;
        t.line_end       = le;
        t.param_overflow = ov;
        return t;
    endfunction

    function automatic stim_row_t open_row(input logic [7:0] d, input logic l);
        stim_row_t s;
        s.data     = d;
        s.last     = l;
        s.typed_in = 1'b0;
        s.tag      = '0;
        return s;
    endfunction

    function automatic stim_row_t typed_row(input logic [7:0] d, input logic l,
                                            input irctok_pkg::tok_result_t t);
        stim_row_t s;
        s.data     = d;
        s.last     = l;
        s.typed_in = 1'b1;
        s.tag      = t;
        return s;
    endfunction

    function automatic logic [7:0] blank_byte();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? 8'h20 : 8'(8'h09 + k);
    endfunction

    function automatic logic [7:0] token_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (blank_char(b));
        return b;
    endfunction

    // First byte of a middle parameter: a colon here would open a trailing one.
    function automatic logic [7:0] param_start_byte();
        logic [7:0] b;
        do b = token_byte(); while (b == irctok_pkg::COLON);
        return b;
    endfunction

    // Noise leans on the delimiters so broken lines hit odd phase paths.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 3))
            0:       return irctok_pkg::COLON;
            1:       return blank_byte();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Append one byte to a line under construction.
    task automatic add_byte(ref logic [7:0] q[$], input logic [7:0] b);
        q = {q, b};
    endtask

    // Offer one byte, idling first at the phase's rate, and hold it until the
    // transfer happens; then record the tag it must produce.
    task automatic push_byte(input logic [7:0] d, input logic l, input logic typed_in,
                             input irctok_pkg::tok_result_t t);
        irctok_pkg::tok_result_t predicted;
        while (int'($urandom_range(0, 99)) < src_idle_pct)
        begin
            line_in.valid <= 1'b0;
            @(posedge clk);
        end
        line_in.valid     <= 1'b1;
        line_in.data_byte <= d;
        line_in.last_byte <= l;
        do @(posedge clk); while (!line_in.ready);
        predicted = classify_byte(d, l);
        pending_tags = {pending_tags, (typed_in ? t : predicted)};
        transfers_in++;
    endtask

    // Mostly well-formed lines with random content: optional prefix, command,
    // a random count of middle parameters (sometimes past the limit, sometimes
    // empty) and an optional trailing one. The rest is short noise.
    task automatic send_random_line();
        logic [7:0] lq[$];
        int         n_params;
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 10)) add_byte(lq, noise_byte());
        end
        else
        begin
            if ($urandom_range(0, 1))
            begin
                add_byte(lq, irctok_pkg::COLON);
                repeat ($urandom_range(0, 1)) add_byte(lq, blank_byte());
                repeat ($urandom_range(1, 6)) add_byte(lq, token_byte());
                add_byte(lq, blank_byte());
            end
            repeat ($urandom_range(0, 2)) add_byte(lq, blank_byte());
            repeat ($urandom_range(1, 5)) add_byte(lq, token_byte());
            n_params = ($urandom_range(0, 99) < 15) ? $urandom_range(14, 20)
                                                    : $urandom_range(0, 5);
            for (int i = 0; i < n_params; i++)
            begin
                add_byte(lq, blank_byte());
                // Skip the content now and then: the next blank ends an empty middle.
                if ($urandom_range(0, 99) >= 20)
                begin
                    add_byte(lq, param_start_byte());
                    repeat ($urandom_range(0, 3)) add_byte(lq, token_byte());
                end
            end
            if ($urandom_range(0, 1))
            begin
                add_byte(lq, blank_byte());
                add_byte(lq, irctok_pkg::COLON);
                repeat ($urandom_range(0, 8)) add_byte(lq, 8'($urandom_range(0, 255)));
            end
        end
        foreach (lq[i])
            push_byte(lq[i], i == lq.size() - 1, 1'b0, '0);
    endtask

    task automatic compare_field(input string fname, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, exp_v, act_v);
            error_count++;
        end
    endtask

    // Receiver: check each transfer against the oldest predicted tag, then
    // pick ready for the next edge (long hold-off when asked, else random stall).
    initial begin : result_check
        int                      hold_left;
        int                      seen_gen;
        irctok_pkg::tok_result_t act;
        irctok_pkg::tok_result_t exp_t;
        hold_left = 0;
        seen_gen  = 0;
        token_out.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (token_out.valid && token_out.ready)
            begin
                act.out_byte       = token_out.out_byte;
                act.byte_valid     = token_out.byte_valid;
                act.field_kind     = irctok_pkg::kind_t'(token_out.field_kind);
                act.param_index    = token_out.param_index;
                act.field_end      = token_out.field_end;
                act.line_end       = token_out.line_end;
                act.param_overflow = token_out.param_overflow;
                if (pending_tags.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, act);
                    error_count++;
                end
                else
                begin
                    exp_t = pending_tags.pop_front();
                    compare_field("out_byte", exp_t.out_byte, act.out_byte);
                    compare_field("byte_valid", exp_t.byte_valid, act.byte_valid);
                    compare_field("field_kind", exp_t.field_kind, act.field_kind);
                    compare_field("param_index", exp_t.param_index, act.param_index);
                    compare_field("field_end", exp_t.field_end, act.field_end);
                    compare_field("line_end", exp_t.line_end, act.line_end);
                    compare_field("param_overflow", exp_t.param_overflow,
                                  act.param_overflow);
                end
            end
            if (hold_gen != seen_gen)
            begin
                seen_gen  = hold_gen;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                token_out.ready <= 1'b0;
            end
            else
                token_out.ready <= (int'($urandom_range(0, 99)) >= sink_stall_pct);
        end
    end

    initial begin : stimulus
        stim_row_t     dir_rows [DIR_ROWS];
        traffic_mode_t schedule [6];
        int            drain_wait;
        rst_n             <= 1'b0;
        line_in.valid     <= 1'b0;
        line_in.data_byte <= 8'h00;
        line_in.last_byte <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_rows = '{
            // Lone colon: prefix opened, no token, nothing completes.
            typed_row(8'h3A, 1'b1,
                      tag(8'h00, 1'b0, irctok_pkg::KIND_PREFIX, 4'd0, 1'b0, 1'b1, 1'b0)),
            // Leading blanks at both ends of the control range are skipped.
            typed_row(8'h09, 1'b0,
                      tag(8'h00, 1'b0, irctok_pkg::KIND_NONE, 4'd0, 1'b0, 1'b0, 1'b0)),
            typed_row(8'h0D, 1'b0,
                      tag(8'h00, 1'b0, irctok_pkg::KIND_NONE, 4'd0, 1'b0, 1'b0, 1'b0)),
            open_row(8'hFF, 1'b0),      // command byte
            open_row(8'h20, 1'b0),      // command separator
            open_row(8'h20, 1'b0),      // empty middle
            open_row(8'h00, 1'b0),      // middle content
            open_row(8'h0C, 1'b0),      // middle separator
            open_row(8'h3A, 1'b0),      // trailing colon
            open_row(8'h7F, 1'b1),      // trailing content ends the line
            // Prefix with a skipped blank, command on non-blank neighbors of the
            // blank range, middle cut by the end of the line.
            open_row(8'h3A, 1'b0),
            open_row(8'h0B, 1'b0),
            open_row(8'h80, 1'b0),
            open_row(8'h0A, 1'b0),
            open_row(8'h08, 1'b0),
            open_row(8'h0E, 1'b0),
            open_row(8'h20, 1'b0),
            open_row(8'h21, 1'b1),
            // Blank at line end right after the prefix separator adds no field.
            open_row(8'h3A, 1'b0),
            open_row(8'h61, 1'b0),
            open_row(8'h20, 1'b0),
            typed_row(8'h20, 1'b1,
                      tag(8'h00, 1'b0, irctok_pkg::KIND_NONE, 4'd0, 1'b0, 1'b1, 1'b0)),
            // Colon as the last byte ends an empty trailing parameter.
            open_row(8'h43, 1'b0),
            open_row(8'h20, 1'b0),
            open_row(8'h3A, 1'b1)
        };
        foreach (dir_rows[i])
            push_byte(dir_rows[i].data, dir_rows[i].last, dir_rows[i].typed_in,
                      dir_rows[i].tag);

        // Random lines; each phase sets its own idle and stall rates.
        schedule = '{MODE_FREE, MODE_SRC_IDLE, MODE_SINK_STALL, MODE_BOTH,
                     MODE_PRESSURE, MODE_FREE};
        foreach (schedule[k])
        begin
            case (schedule[k])
                MODE_SRC_IDLE:
                begin
                    src_idle_pct   = 81;
                    sink_stall_pct = 0;
                end
                MODE_SINK_STALL:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 81;
                end
                MODE_BOTH:
                begin
                    src_idle_pct   = 25;
                    sink_stall_pct = 25;
                end
                MODE_PRESSURE:
                begin
                    // Receiver holds off while the sender keeps offering:
                    // the block fills and must stall its input.
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    hold_gen++;
                end
                default:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            while (transfers_in < DIR_ROWS + (k + 1) * PHASE_ITEMS)
                send_random_line();
        end
        line_in.valid <= 1'b0;

        // Drain: wait for every predicted tag, then keep watching for strays.
        drain_wait = 0;
        while (pending_tags.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        if (pending_tags.size() != 0)
        begin
            $display("%0t: missing results: expected %0d more, actual 0",
                     $time, pending_tags.size());
            error_count++;
        end
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
